// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while dis is true.
`define ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Next-cycle implication, switched off while dis is true.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// File: sv/ita_pkg.sv
package ita_pkg;

  localparam int VALUE_W = 64;
  localparam int DEC_W   = 32;
  localparam int NIB_W   = 4;
  localparam int IDX_W   = 4;
  localparam int CHAR_W  = 8;
  localparam int CNT_W   = 5;
  localparam int ACT_W   = 2;
  localparam int NIBBLES = VALUE_W / NIB_W;

  localparam logic [ACT_W-1:0] ACT_SDEC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UDEC = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HEXL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_HEXU = 2'd3;

  // Ten decimal digits cover every 32-bit magnitude.
  localparam int DEC_DIGITS = 10;

  // Division by ten: q = (w * 0xCCCCCCCD) >> 35, exact for all 32-bit w.
  localparam logic [DEC_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int               DIV10_SHIFT = 35;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWA  = 8'h61;

  // A classified job as it travels from the front to the back.
  typedef struct packed {
    logic               is_hex;
    logic               upper;
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [IDX_W-1:0]   top;
  } ita_job_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib,
                                                 input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-NIB_W){1'b0}}, nib};
    if (nib < 4'd10) begin
      hex_char = ASCII_ZERO + ext;
    end else if (upper) begin
      hex_char = ASCII_UPA + ext - 8'd10;
    end else begin
      hex_char = ASCII_LOWA + ext - 8'd10;
    end
  endfunction

endpackage

// File: sv/ita_front.sv
module ita_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ita_pkg::VALUE_W-1:0] value,
  input  logic [ita_pkg::ACT_W-1:0]   action,
  input  logic                        fifo_full,
  output logic                        busy,
  output logic                        push,
  output ita_pkg::ita_job_t           job
);
  import ita_pkg::*;

  logic               valid_r, valid_nxt;
  ita_job_t           job_r;
  ita_job_t           cls;
  logic               accept;
  logic [DEC_W-1:0]   low;
  logic [DEC_W-1:0]   mag_dec;

  // Classify the incoming number: sign, magnitude and top hex digit.
  always_comb begin
    low        = value[DEC_W-1:0];
    cls.is_hex = action[1];
    cls.upper  = (action == ACT_HEXU);
    cls.neg    = (action == ACT_SDEC) && low[DEC_W-1];
    mag_dec    = cls.neg ? (32'd0 - low) : low;
    cls.mag    = cls.is_hex ? value : {{(VALUE_W-DEC_W){1'b0}}, mag_dec};
    cls.top    = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      if (value[i*NIB_W +: NIB_W] != '0) begin
        cls.top = IDX_W'(i);
      end
    end
  end

  assign push      = valid_r && !fifo_full;
  assign busy      = valid_r && fifo_full;
  assign accept    = start && !busy;
  assign valid_nxt = accept || (valid_r && !push);
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= cls;
    end
  end

endmodule

// File: sv/ita_fifo.sv
module ita_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ita_pkg::ita_job_t wdata,
  output logic              full,
  input  logic              pop,
  output ita_pkg::ita_job_t rdata,
  output logic              empty
);
  import ita_pkg::*;

  ita_job_t                slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [FIFO_PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign full    = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: sv/ita_back.sv
module ita_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       empty,
  input  ita_pkg::ita_job_t          job,
  output logic                       pop,
  output logic                       strobe,
  output logic [ita_pkg::CHAR_W-1:0] char_code,
  output logic                       is_last,
  output logic [ita_pkg::CNT_W-1:0]  char_count
);
  import ita_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]           st_r, st_nxt;
  logic                 hex_r, hex_nxt;
  logic                 upper_r, upper_nxt;
  logic                 sign_r, sign_nxt;
  logic                 neg_r, neg_nxt;
  logic [VALUE_W-1:0]   hexval_r, hexval_nxt;
  logic [DEC_W-1:0]     w_r, w_nxt;
  logic [2*DEC_W-1:0]   prod_r, prod_nxt;
  logic [IDX_W-1:0]     wptr_r, wptr_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [NIB_W-1:0]     dig_r [DEC_DIGITS];
  logic                 dig_we;
  logic [NIB_W-1:0]     dig_wdata;
  logic                 strobe_r, strobe_nxt;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r, last_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [DEC_W-1:0]     quot;
  logic [DEC_W-1:0]     rem;

  always_comb begin
    st_nxt     = st_r;
    hex_nxt    = hex_r;
    upper_nxt  = upper_r;
    sign_nxt   = sign_r;
    neg_nxt    = neg_r;
    hexval_nxt = hexval_r;
    w_nxt      = w_r;
    prod_nxt   = prod_r;
    wptr_nxt   = wptr_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    pop        = 1'b0;
    dig_we     = 1'b0;
    quot       = {{(DEC_W-(2*DEC_W-DIV10_SHIFT)){1'b0}}, prod_r[2*DEC_W-1:DIV10_SHIFT]};
    rem        = w_r - ((quot << 3) + (quot << 1));
    dig_wdata  = rem[NIB_W-1:0];
    unique case (st_r)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          hex_nxt    = job.is_hex;
          upper_nxt  = job.upper;
          neg_nxt    = job.neg;
          hexval_nxt = job.mag;
          w_nxt      = job.mag[DEC_W-1:0];
          wptr_nxt   = '0;
          if (job.is_hex) begin
            idx_nxt   = job.top;
            total_nxt = {1'b0, job.top} + 5'd1;
            sign_nxt  = 1'b0;
            st_nxt    = ST_EMIT;
          end else begin
            sign_nxt = job.neg;
            st_nxt   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt = {{DEC_W{1'b0}}, w_r} * {{DEC_W{1'b0}}, DIV10_MAGIC};
        st_nxt   = ST_DIV;
      end
      ST_DIV: begin
        dig_we = 1'b1;
        w_nxt  = quot;
        if (quot == '0) begin
          idx_nxt   = wptr_r;
          total_nxt = {1'b0, wptr_r} + 5'd1 + {{(CNT_W-1){1'b0}}, neg_r};
          st_nxt    = ST_EMIT;
        end else begin
          wptr_nxt = wptr_r + 1'b1;
          st_nxt   = ST_MUL;
        end
      end
      ST_EMIT: begin
        strobe_nxt = 1'b1;
        if (sign_r) begin
          char_nxt  = ASCII_MINUS;
          last_nxt  = 1'b0;
          count_nxt = '0;
          sign_nxt  = 1'b0;
        end else begin
          char_nxt = hex_r ? hex_char(hexval_r[{idx_r, 2'b00} +: NIB_W], upper_r)
                           : ASCII_ZERO + {{(CHAR_W-NIB_W){1'b0}}, dig_r[idx_r]};
          if (idx_r == '0) begin
            last_nxt  = 1'b1;
            count_nxt = total_r;
            st_nxt    = ST_IDLE;
          end else begin
            last_nxt  = 1'b0;
            count_nxt = '0;
            idx_nxt   = idx_r - 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hex_r    <= hex_nxt;
    upper_r  <= upper_nxt;
    sign_r   <= sign_nxt;
    neg_r    <= neg_nxt;
    hexval_r <= hexval_nxt;
    w_r      <= w_nxt;
    prod_r   <= prod_nxt;
    wptr_r   <= wptr_nxt;
    idx_r    <= idx_nxt;
    total_r  <= total_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
    count_r  <= count_nxt;
    if (dig_we) begin
      dig_r[wptr_r] <= dig_wdata;
    end
  end

  assign strobe     = strobe_r;
  assign char_code  = char_r;
  assign is_last    = last_r;
  assign char_count = count_r;

endmodule

// File: sv/integer_to_ascii_formatter.sv
// A hex number goes straight to its characters. A decimal number first runs the
// divide-by-ten multiplier in the back end once per digit, and only then shows
// its sign, if any, and its digits. The back end takes no new number from the
// queue before the last character of the current one is on the output.
// Reset: synchronous, active low; the queue empties and no character is shown.
// The receiver cannot stall: each character is shown for one cycle only.
module integer_to_ascii_formatter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ita_pkg::VALUE_W-1:0] in_value,
  input  logic [ita_pkg::ACT_W-1:0]   in_action,
  output logic                        out_strobe,
  output logic [ita_pkg::CHAR_W-1:0]  out_char_code,
  output logic                        out_is_last,
  output logic [ita_pkg::CNT_W-1:0]   out_char_count
);
  import ita_pkg::*;

  // The front end takes one beat, works out the sign, the magnitude and the
  // position of the highest non-zero hex digit, and holds the result until
  // the queue has room. Busy is high only while that holding stage is stuck.
  ita_job_t front_job;
  logic     front_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  ita_job_t q_job;

  ita_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .value     (in_value),
    .action    (in_action),
    .fifo_full (q_full),
    .busy      (busy),
    .push      (front_push),
    .job       (front_job)
  );

  // A two-entry queue lets the front end keep taking numbers while the back
  // end is still producing characters for an earlier one.
  ita_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_job),
    .empty (q_empty)
  );

  // The back end turns a job into characters. Hex digits are read straight
  // from the nibbles, most significant first. Decimal digits come out least
  // significant first from repeated division by ten, so they are kept in a
  // small digit buffer and then played back in reverse, after the sign.
  ita_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .job        (q_job),
    .pop        (q_pop),
    .strobe     (out_strobe),
    .char_code  (out_char_code),
    .is_last    (out_is_last),
    .char_count (out_char_count)
  );

endmodule

// File: sv/ita_checker.sv
`include "assert_macros.svh"

module ita_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [ita_pkg::VALUE_W-1:0] in_value,
  input logic [ita_pkg::ACT_W-1:0]   in_action,
  input logic                        out_strobe,
  input logic [ita_pkg::CHAR_W-1:0]  out_char_code,
  input logic                        out_is_last,
  input logic [ita_pkg::CNT_W-1:0]   out_char_count
);

  // Reset leaves no character on the output.
  `ASSERT_NEXT(a_reset_quiet, clk, 1'b0, !rst_n, !out_strobe)

  // The count is zero on every character but the last.
  `ASSERT_SAME(a_count_zero, clk, !rst_n, out_strobe && !out_is_last, out_char_count == 5'd0)

  // The last character carries a count from one to sixteen.
  `ASSERT_SAME(a_count_range, clk, !rst_n, out_strobe && out_is_last,
               (out_char_count != 5'd0) && (out_char_count <= 5'd16))

  // Characters of one number come out back to back.
  `ASSERT_NEXT(a_no_gap, clk, !rst_n, out_strobe && !out_is_last, out_strobe)

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (.*);
